// ----- design/uplc_pkg.sv -----
// Shared types and constants of the unsatisfied parity line counter.
`default_nettype none

package uplc_pkg;

   localparam int unsigned LINE_FIELDS      = 3;
   localparam int unsigned POINT_FIELD_BITS = 12;
   localparam int unsigned COUNT_FIELD_BITS = 16;

   typedef enum logic [1:0] {
      OP_WRITE_BIT   = 2'd0,
      OP_CHECK_LINE  = 2'd1,
      OP_READ_COUNT  = 2'd2,
      OP_CLEAR_COUNT = 2'd3
   } op_type;

   typedef struct packed {
      op_type                      opcode;
      logic [POINT_FIELD_BITS-1:0] point_addr;
      logic                        bit_value;
      logic [POINT_FIELD_BITS-1:0] point_0;
      logic [POINT_FIELD_BITS-1:0] point_1;
      logic [POINT_FIELD_BITS-1:0] point_2;
      logic                        negativity;
   } req_type;

   typedef struct packed {
      logic                        line_invalid;
      logic [COUNT_FIELD_BITS-1:0] count_value;
   } rsp_type;

   typedef enum logic [1:0] {
      CNT_READ  = 2'd0,
      CNT_INC   = 2'd1,
      CNT_CLEAR = 2'd2
   } cnt_op_type;

   typedef struct packed {
      logic       valid;
      cnt_op_type op;
   } cnt_cmd_type;

endpackage

`default_nettype wire

// ----- design/unsatisfied_parity_line_counter.sv -----
// Unsatisfied parity line counter: top level with lanes, parity merge and sequencer.
//
// Each transfer on req yields exactly one transfer on rsp. Writing an assignment bit or
// clearing a count finishes in the idle state; reading a count passes a read state, a
// satisfied line a check state, and a violated line the check state and the increment
// steps: the parity is found in one step by one assignment memory copy per point, then
// the single port of the counter memory does one read-modify-write per point of the line.
// A finished result sits in the rsp output register, so the next request is taken while
// it waits. After reset all 2**POINT_BITS entries (4096 by default) of the counter memory
// are swept to zero with req_ready low; the block holds one request at a time.
`default_nettype none

module unsatisfied_parity_line_counter #(
   parameter int unsigned POINT_BITS      = 12,
   parameter int unsigned POINTS_PER_LINE = 3,
   parameter int unsigned COUNT_BITS      = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire uplc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output uplc_pkg::rsp_type      rsp_data
);

   localparam int unsigned LANES = (POINTS_PER_LINE < uplc_pkg::LINE_FIELDS) ?
                                   POINTS_PER_LINE : uplc_pkg::LINE_FIELDS;
   localparam int unsigned KW    = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int unsigned PEXT  = (POINT_BITS > uplc_pkg::POINT_FIELD_BITS) ?
                                   POINT_BITS : uplc_pkg::POINT_FIELD_BITS;
   localparam int unsigned CEXT  = (COUNT_BITS > uplc_pkg::COUNT_FIELD_BITS) ?
                                   COUNT_BITS : uplc_pkg::COUNT_FIELD_BITS;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_INC   = 5'b00100,
      S_READ  = 5'b01000,
      S_HOLD  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [KW-1:0]         k_ff, k_in;
   logic                  neg_ff;
   logic [POINT_BITS-1:0] pt_addr_ff [LANES];
   uplc_pkg::rsp_type     hold_ff, hold_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   uplc_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic                                  accept;
   logic                                  clr_busy;
   logic [uplc_pkg::POINT_FIELD_BITS-1:0] req_pt_raw [uplc_pkg::LINE_FIELDS];
   logic [PEXT-1:0]                       pt_ext [LANES];
   logic [POINT_BITS-1:0]                 req_pt [LANES];
   logic [PEXT-1:0]                       addr_ext;
   logic [POINT_BITS-1:0]                 req_addr;
   logic [LANES-1:0]                      lane_bit;
   logic                                  parity;
   logic                                  lane_wr;
   logic                                  lane_rd;

   uplc_pkg::cnt_cmd_type cnt_cmd;
   logic [POINT_BITS-1:0] cnt_addr;
   logic [COUNT_BITS-1:0] cnt_value;
   logic [CEXT-1:0]       cnt_ext;

   logic              fin_valid;
   uplc_pkg::rsp_type fin_data;
   logic              out_free;

   assign req_ready = (state_ff == S_IDLE) && !clr_busy;
   assign accept    = req_valid && req_ready;

   assign req_pt_raw[0] = req_data.point_0;
   assign req_pt_raw[1] = req_data.point_1;
   assign req_pt_raw[2] = req_data.point_2;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         pt_ext[i] = PEXT'(req_pt_raw[i]);
         req_pt[i] = pt_ext[i][POINT_BITS-1:0];
      end
   end

   assign addr_ext = PEXT'(req_data.point_addr);
   assign req_addr = addr_ext[POINT_BITS-1:0];

   assign lane_wr = accept && (req_data.opcode == uplc_pkg::OP_WRITE_BIT);
   assign lane_rd = accept && (req_data.opcode == uplc_pkg::OP_CHECK_LINE);

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      uplc_bit_lane #(
         .POINT_BITS(POINT_BITS)
      ) u_lane (
         .clock  (clock),
         .wr_en  (lane_wr),
         .wr_addr(req_addr),
         .wr_bit (req_data.bit_value),
         .rd_en  (lane_rd),
         .rd_addr(req_pt[l]),
         .rd_bit (lane_bit[l])
      );
   end

   // merge of the lanes
   assign parity = ^lane_bit;

   uplc_count_unit #(
      .POINT_BITS(POINT_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_count (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cnt_cmd),
      .cmd_addr(cnt_addr),
      .busy    (clr_busy),
      .value   (cnt_value)
   );

   assign cnt_ext  = CEXT'(cnt_value);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      cnt_cmd.valid = 1'b0;
      cnt_cmd.op    = uplc_pkg::CNT_READ;
      cnt_addr      = req_addr;
      fin_valid     = 1'b0;
      fin_data      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  uplc_pkg::OP_CHECK_LINE: begin
                     state_in = S_CHECK;
                  end
                  uplc_pkg::OP_READ_COUNT: begin
                     cnt_cmd.valid = 1'b1;
                     state_in      = S_READ;
                  end
                  uplc_pkg::OP_CLEAR_COUNT: begin
                     cnt_cmd.valid = 1'b1;
                     cnt_cmd.op    = uplc_pkg::CNT_CLEAR;
                     fin_valid     = 1'b1;
                  end
                  default: begin
                     fin_valid = 1'b1;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (parity != neg_ff) begin
               cnt_cmd.valid = 1'b1;
               cnt_cmd.op    = uplc_pkg::CNT_INC;
               cnt_addr      = pt_addr_ff[0];
               k_in          = KW'(1);
               state_in      = S_INC;
            end else begin
               fin_valid = 1'b1;
            end
         end
         S_INC: begin
            cnt_cmd.valid = 1'b1;
            cnt_cmd.op    = uplc_pkg::CNT_INC;
            cnt_addr      = pt_addr_ff[k_ff];
            if (k_ff == KW'(LANES - 1)) begin
               fin_valid             = 1'b1;
               fin_data.line_invalid = 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_READ: begin
            fin_valid            = 1'b1;
            fin_data.count_value = cnt_ext[uplc_pkg::COUNT_FIELD_BITS-1:0];
         end
         S_HOLD: begin
            fin_valid = 1'b1;
            fin_data  = hold_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      hold_in      = hold_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fin_valid) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = fin_data;
            state_in     = S_IDLE;
         end else begin
            hold_in  = fin_data;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         neg_ff <= req_data.negativity;
         for (int i = 0; i < LANES; i++) begin
            pt_addr_ff[i] <= req_pt[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_cmd_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cnt_cmd.valid |-> !clr_busy)
      else $error("counter command during clearing pass");

   a_sweep_once: assert property (@(posedge clock) disable iff (reset)
      !clr_busy |=> !clr_busy)
      else $error("clearing pass restarted");

   a_lane_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INC) |-> (k_ff <= KW'(LANES - 1)))
      else $error("increment step beyond last point");

   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> !req_ready)
      else $error("request taken while a result is held");

endmodule

`default_nettype wire

// ----- design/uplc_bit_lane.sv -----
// One lane: a copy of the assignment bit memory with a registered read port.
`default_nettype none

module uplc_bit_lane #(
   parameter int unsigned POINT_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [POINT_BITS-1:0] wr_addr,
   input  wire logic                  wr_bit,
   input  wire logic                  rd_en,
   input  wire logic [POINT_BITS-1:0] rd_addr,
   output logic                       rd_bit
);

   localparam int unsigned DEPTH = 2 ** POINT_BITS;

   logic bit_mem_ff [DEPTH];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bit_mem_ff[wr_addr] <= wr_bit;
      end
      if (rd_en) begin
         rd_bit_ff <= bit_mem_ff[rd_addr];
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

`default_nettype wire

// ----- design/uplc_count_unit.sv -----
// Point counter memory: clearing pass, read/increment/clear pipeline with forwarding.
`default_nettype none

module uplc_count_unit #(
   parameter int unsigned POINT_BITS = 12,
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire uplc_pkg::cnt_cmd_type  cmd,
   input  wire logic [POINT_BITS-1:0]  cmd_addr,
   output logic                        busy,
   output logic [COUNT_BITS-1:0]       value
);

   localparam int unsigned DEPTH = 2 ** POINT_BITS;

   logic [COUNT_BITS-1:0] cnt_mem_ff [DEPTH];
   logic [COUNT_BITS-1:0] rd_q_ff;

   logic                  clr_busy_ff, clr_busy_in;
   logic [POINT_BITS-1:0] clr_addr_ff, clr_addr_in;

   logic                   s1_valid_ff;
   uplc_pkg::cnt_op_type   s1_op_ff;
   logic [POINT_BITS-1:0]  s1_addr_ff;

   logic                  fw_valid_ff;
   logic [POINT_BITS-1:0] fw_addr_ff;
   logic [COUNT_BITS-1:0] fw_data_ff;

   logic                  wr_en;
   logic [POINT_BITS-1:0] wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [COUNT_BITS-1:0] cur;

   // the write committed at the last edge is missing from the registered read
   assign cur = (fw_valid_ff && (fw_addr_ff == s1_addr_ff)) ? fw_data_ff : rd_q_ff;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      wr_en       = 1'b0;
      wr_addr     = s1_addr_ff;
      wr_data     = '0;
      if (clr_busy_ff) begin
         wr_en       = 1'b1;
         wr_addr     = clr_addr_ff;
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end else if (s1_valid_ff) begin
         case (s1_op_ff)
            uplc_pkg::CNT_INC: begin
               wr_en   = 1'b1;
               wr_data = (cur == '1) ? cur : cur + 1'b1;
            end
            uplc_pkg::CNT_CLEAR: begin
               wr_en = 1'b1;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.valid) begin
         rd_q_ff <= cnt_mem_ff[cmd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= cmd.valid;
         fw_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         s1_op_ff   <= cmd.op;
         s1_addr_ff <= cmd_addr;
      end
      if (wr_en) begin
         fw_addr_ff <= wr_addr;
         fw_data_ff <= wr_data;
      end
   end

   assign busy  = clr_busy_ff;
   assign value = cur;

endmodule

`default_nettype wire
